@@ hw/rtl/audio_clip_meter_rate_change_top_defines.svh @@
// ----------------------------------------------------------------------------
// audio clip meter assertion macros
// shared assertion forms for the clip meter and rate changer
// ----------------------------------------------------------------------------
`ifndef AUDIO_CLIP_METER_RATE_CHANGE_TOP_DEFINES_SVH
`define AUDIO_CLIP_METER_RATE_CHANGE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk and idle during reset
`define ACMRC_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk and idle during reset
`define ACMRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/acmrc_pkg.sv @@
// ----------------------------------------------------------------------------
// acmrc_pkg
// types and fixed constants of the audio clip meter and rate changer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acmrc_pkg;

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // field widths
    localparam int SAMPLE_IN_W  = 20;
    localparam int SAMPLE_OUT_W = 17;
    localparam int PEAK_W       = 20;

    // clip limits, plus or minus 1.0 in q15
    localparam logic signed [SAMPLE_IN_W-1:0]  CLIP_HI = 20'sd32768;
    localparam logic signed [SAMPLE_IN_W-1:0]  CLIP_LO = -20'sd32768;
    localparam logic signed [SAMPLE_OUT_W-1:0] SAMP_HI = 17'sd32768;
    localparam logic signed [SAMPLE_OUT_W-1:0] SAMP_LO = -17'sd32768;

    // rate modes
    localparam logic [1:0] MODE_UNITY   = 2'd0;
    localparam logic [1:0] MODE_AVERAGE = 2'd1;
    localparam logic [1:0] MODE_REPEAT  = 2'd2;

    // register indexes (word address)
    localparam logic [1:0] REG_METER_WINDOW = 2'd0;
    localparam logic [1:0] REG_WINDOWED     = 2'd1;
    localparam logic [1:0] REG_RATE_MODE    = 2'd2;
    localparam logic [1:0] REG_RATE_FACTOR  = 2'd3;

    // register reset values
    localparam logic [15:0] METER_WINDOW_RST = 16'd1024;
    localparam logic        WINDOWED_RST     = 1'b1;
    localparam logic [1:0]  RATE_MODE_RST    = MODE_UNITY;
    localparam logic [4:0]  RATE_FACTOR_RST  = 5'd2;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ hw/rtl/acmrc_div.sv @@
// ----------------------------------------------------------------------------
// acmrc_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acmrc_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]    den,
    output logic [NUM_W-1:0]    quot,
    output acmrc_pkg::div_stat_t stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // shift in the next numerator bit and try a subtract
    assign trial = {rem_reg, quot_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
            rem_reg  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ hw/rtl/audio_clip_meter_rate_change_top.sv @@
// ----------------------------------------------------------------------------
// audio_clip_meter_rate_change_top
// one-channel peak meter, clipper and integer rate changer
// ----------------------------------------------------------------------------
//  channel   | dir | beat contents
//  s_*       | in  | tdata: mixed_sample q4.15, tlast: frag_last
//  m_*       | out | tdata: out_sample, peak_level; tuser: sample/peak valid;
//            |     | tlast: last result of the input sample
//  apb       | in  | meter_window, windowed_metering, rate_mode, rate_factor
//
//  a sample takes an accept state and an update state, then one result beat
//  per cycle while the output is not stalled; when an averaging group closes
//  the serial divider runs between the update and the result beat. repeat
//  mode sends n_eff result beats. one sample is in flight at a time.
//  output stalls hold the last result in the output register; s_tready
//  returns once the final beat of a sample is loaded there.
//  reset clears the meter and the averaging group and reloads the registers' reset values at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "audio_clip_meter_rate_change_top_defines.svh"

module audio_clip_meter_rate_change_top #(
    parameter int MAX_RATE_FACTOR = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // stream in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [acmrc_pkg::S_TDATA_W-1:0]     s_tdata,  // [19:0] mixed_sample
    input  logic                                s_tlast,
    // stream out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [acmrc_pkg::M_TDATA_W-1:0]     m_tdata,  // [16:0] out_sample, [36:17] peak_level
    output logic [acmrc_pkg::M_TUSER_W-1:0]     m_tuser,  // [0] sample_valid, [1] peak_valid
    output logic                                m_tlast,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int NW    = $clog2(MAX_RATE_FACTOR + 1);
    localparam int FW    = (NW > 5) ? NW : 5;
    localparam int MAG_W = $clog2(MAX_RATE_FACTOR * 32768 + 1);
    localparam int SUM_W = MAG_W + 1;
    localparam int IW    = acmrc_pkg::SAMPLE_IN_W;
    localparam int OW    = acmrc_pkg::SAMPLE_OUT_W;
    localparam int PW    = acmrc_pkg::PEAK_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    // registers
    logic [15:0]            meter_window_reg;
    logic                   windowed_reg;
    logic [1:0]             rate_mode_reg;
    logic [4:0]             rate_factor_reg;

    logic [1:0]             state_reg, state_next;
    logic signed [IW-1:0]   window_min_reg, window_min_next;
    logic signed [IW-1:0]   window_max_reg, window_max_next;
    logic [15:0]            window_count_reg, window_count_next;
    logic signed [SUM_W-1:0] group_sum_reg, group_sum_next;
    logic [NW-1:0]          group_cnt_reg, group_cnt_next;
    logic [NW-1:0]          rep_cnt_reg, rep_cnt_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    logic signed [IW-1:0]   x_reg;
    logic                   frag_reg;
    logic signed [OW-1:0]   samp_reg, samp_next;
    logic                   sv_reg, sv_next;
    logic                   pv_reg, pv_next;
    logic [PW-1:0]          peak_reg, peak_next;
    logic [NW-1:0]          reps_reg, reps_next;
    logic                   neg_reg, neg_next;
    logic [acmrc_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [acmrc_pkg::M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic                   m_tlast_reg, m_tlast_next;

    // datapath
    logic [FW-1:0]          rf_ext;
    logic [NW-1:0]          n_eff;
    logic signed [IW-1:0]   wmax_new, wmin_new;
    logic                   win_close;
    logic signed [IW:0]     amax_s, amin_s;
    logic [PW-1:0]          peak_val;
    logic signed [OW-1:0]   clip_val;
    logic signed [SUM_W-1:0] sum_acc;
    logic [NW-1:0]          gcnt_inc;
    logic                   group_close;
    logic                   sum_neg;
    logic [MAG_W-1:0]       sum_mag;
    logic                   div_start;
    logic [MAG_W-1:0]       div_quot;
    acmrc_pkg::div_stat_t   div_stat;
    logic signed [OW-1:0]   quot_mag;
    logic                   out_free;
    logic                   first_beat;
    logic                   cfg_wr;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;

    // effective factor: zero acts as one, large values saturate
    always_comb
    begin
        rf_ext = FW'(rate_factor_reg);
        if (rf_ext == '0)
            n_eff = NW'(1);
        else if (rf_ext > FW'(MAX_RATE_FACTOR))
            n_eff = NW'(MAX_RATE_FACTOR);
        else
            n_eff = NW'(rf_ext);
    end

    // metering on the unclipped sample
    assign wmax_new  = (x_reg > window_max_reg) ? x_reg : window_max_reg;
    assign wmin_new  = (x_reg < window_min_reg) ? x_reg : window_min_reg;
    assign win_close = frag_reg |
        (windowed_reg & (({1'b0, window_count_reg} + 17'd1) >= {1'b0, meter_window_reg}));
    assign amax_s    = (IW+1)'(wmax_new);
    assign amin_s    = -((IW+1)'(wmin_new));
    assign peak_val  = (amax_s > amin_s) ? amax_s[PW-1:0] : amin_s[PW-1:0];

    always_comb
    begin
        if (x_reg > acmrc_pkg::CLIP_HI)
            clip_val = acmrc_pkg::SAMP_HI;
        else if (x_reg < acmrc_pkg::CLIP_LO)
            clip_val = acmrc_pkg::SAMP_LO;
        else
            clip_val = x_reg[OW-1:0];
    end

    // averaging group
    assign sum_acc     = group_sum_reg + SUM_W'(clip_val);
    assign gcnt_inc    = group_cnt_reg + 1'b1;
    assign group_close = (gcnt_inc >= n_eff);
    assign sum_neg     = sum_acc[SUM_W-1];
    assign sum_mag     = sum_neg ? MAG_W'(-sum_acc) : MAG_W'(sum_acc);
    assign div_start   = (state_reg == ST_CALC) &&
                         (rate_mode_reg == acmrc_pkg::MODE_AVERAGE) && group_close;
    assign quot_mag    = div_quot[OW-1:0];

    acmrc_div #(
        .NUM_W (MAG_W),
        .DEN_W (NW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_mag),
        .den   (n_eff),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    assign out_free   = !m_tvalid_reg || m_tready;
    assign first_beat = (rep_cnt_reg == '0);

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        window_min_next   = window_min_reg;
        window_max_next   = window_max_reg;
        window_count_next = window_count_reg;
        group_sum_next    = group_sum_reg;
        group_cnt_next    = group_cnt_reg;
        rep_cnt_next      = rep_cnt_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        samp_next         = samp_reg;
        sv_next           = sv_reg;
        pv_next           = pv_reg;
        peak_next         = peak_reg;
        reps_next         = reps_reg;
        neg_next          = neg_reg;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;
        m_tlast_next      = m_tlast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (win_close)
                begin
                    window_min_next   = '0;
                    window_max_next   = '0;
                    window_count_next = '0;
                end
                else
                begin
                    window_min_next   = wmin_new;
                    window_max_next   = wmax_new;
                    window_count_next = window_count_reg + 1'b1;
                end
                samp_next    = clip_val;
                sv_next      = 1'b1;
                pv_next      = win_close;
                peak_next    = peak_val;
                reps_next    = NW'(1);
                rep_cnt_next = '0;
                neg_next     = sum_neg;
                state_next   = ST_EMIT;
                case (rate_mode_reg)
                    acmrc_pkg::MODE_AVERAGE:
                    begin
                        if (group_close)
                        begin
                            group_sum_next = '0;
                            group_cnt_next = '0;
                            state_next     = ST_DIV;
                        end
                        else
                        begin
                            group_sum_next = sum_acc;
                            group_cnt_next = gcnt_inc;
                            sv_next        = 1'b0;
                            // nothing to send unless the window closed
                            state_next     = win_close ? ST_EMIT : ST_IDLE;
                        end
                    end
                    acmrc_pkg::MODE_REPEAT:
                    begin
                        reps_next = n_eff;
                    end
                    default:
                    begin
                        reps_next = NW'(1);
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    samp_next  = neg_reg ? -quot_mag : quot_mag;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = acmrc_pkg::M_TDATA_W'({
                        ((pv_reg && first_beat) ? peak_reg : PW'(0)),
                        (sv_reg ? samp_reg : OW'(0))});
                    m_tuser_next  = {pv_reg && first_beat, sv_reg};
                    m_tlast_next  = (rep_cnt_reg == reps_reg - 1'b1);
                    if (rep_cnt_reg == reps_reg - 1'b1)
                    begin
                        rep_cnt_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        rep_cnt_next = rep_cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_min_reg   <= '0;
            window_max_reg   <= '0;
            window_count_reg <= '0;
            group_sum_reg    <= '0;
            group_cnt_reg    <= '0;
            rep_cnt_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
            meter_window_reg <= acmrc_pkg::METER_WINDOW_RST;
            windowed_reg     <= acmrc_pkg::WINDOWED_RST;
            rate_mode_reg    <= acmrc_pkg::RATE_MODE_RST;
            rate_factor_reg  <= acmrc_pkg::RATE_FACTOR_RST;
        end
        else
        begin
            state_reg        <= state_next;
            window_min_reg   <= window_min_next;
            window_max_reg   <= window_max_next;
            window_count_reg <= window_count_next;
            group_sum_reg    <= group_sum_next;
            group_cnt_reg    <= group_cnt_next;
            rep_cnt_reg      <= rep_cnt_next;
            m_tvalid_reg     <= m_tvalid_next;
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    acmrc_pkg::REG_METER_WINDOW: meter_window_reg <= pwdata[15:0];
                    acmrc_pkg::REG_WINDOWED:     windowed_reg     <= pwdata[0];
                    acmrc_pkg::REG_RATE_MODE:    rate_mode_reg    <= pwdata[1:0];
                    acmrc_pkg::REG_RATE_FACTOR:  rate_factor_reg  <= pwdata[4:0];
                    default:                     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            x_reg    <= s_tdata[IW-1:0];
            frag_reg <= s_tlast;
        end
        samp_reg    <= samp_next;
        sv_reg      <= sv_next;
        pv_reg      <= pv_next;
        peak_reg    <= peak_next;
        reps_reg    <= reps_next;
        neg_reg     <= neg_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_comb
    begin
        case (paddr[3:2])
            acmrc_pkg::REG_METER_WINDOW: prdata = 32'(meter_window_reg);
            acmrc_pkg::REG_WINDOWED:     prdata = 32'(windowed_reg);
            acmrc_pkg::REG_RATE_MODE:    prdata = 32'(rate_mode_reg);
            acmrc_pkg::REG_RATE_FACTOR:  prdata = 32'(rate_factor_reg);
            default:                     prdata = '0;
        endcase
    end

    // checks
    `ACMRC_ASSERT_NEXT(a_one_sample, s_tvalid && s_tready, !s_tready, "taken while busy")
    `ACMRC_ASSERT_HOLD(a_group_bound, 1'b1, group_cnt_reg <= NW'(MAX_RATE_FACTOR), "group overrun")
    `ACMRC_ASSERT_HOLD(a_rep_bound, state_reg == ST_EMIT, rep_cnt_reg < reps_reg, "repeat overrun")
    `ACMRC_ASSERT_HOLD(a_idle_sample, m_tvalid && !m_tuser[0], m_tdata[OW-1:0] == '0, "idle sample")
    `ACMRC_ASSERT_NEXT(a_div_to_emit, div_stat.done, state_reg == ST_EMIT, "div result lost")

endmodule
